// ===== sv/jesc_pkg.sv =====
package jesc_pkg;

  localparam int COORD_W = 32;
  localparam int PIX_W   = 10;
  localparam int STEP_W  = 9;
  localparam int COLOR_W = 24;
  localparam int CFG_IDX_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_C_REAL  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C_IMAG  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_SCALE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE = 8'd3;

  localparam logic [31:0] SCALE_RESET = 32'd13107200;

  localparam logic [COLOR_W-1:0] COLOR_BLACK = 24'h000000;
  localparam logic [COLOR_W-1:0] COLOR_DARK  = 24'h404040;
  localparam logic [COLOR_W-1:0] COLOR_MID   = 24'h808080;
  localparam logic [COLOR_W-1:0] COLOR_LIGHT = 24'hbfbfbf;
  localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hffffff;

  localparam logic [15:0] TIER_DARK_MIN  = 16'd11;
  localparam logic [15:0] TIER_MID_MIN   = 16'd21;
  localparam logic [15:0] TIER_LIGHT_MIN = 16'd60;

  // 2.0 in Q10.28 and 4.0 in Q8.56
  localparam logic signed [37:0] TWO_Q28  = 38'sd536870912;
  localparam logic [63:0]        FOUR_Q56 = 64'h0400_0000_0000_0000;

  // pixel arithmetic width, holds +/-2^19 offset plus screen size
  localparam int PSUM_W = 24;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_real;
    logic signed [COORD_W-1:0] point_imag;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic               offscreen;
    logic [STEP_W-1:0]  escape_step;
    logic               escaped;
    logic [COLOR_W-1:0] pixel_color;
  } out_t;

  // item handed from front to back
  typedef struct packed {
    logic signed [COORD_W-1:0] z_re;
    logic signed [COORD_W-1:0] z_im;
    logic [PIX_W-1:0]          pixel_x;
    logic [PIX_W-1:0]          pixel_y;
    logic                      offscreen;
  } job_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_ADD
  } back_state_t;

  function automatic logic [COLOR_W-1:0] tier_color(input logic [15:0] s);
    logic [COLOR_W-1:0] c;
    if (s < TIER_DARK_MIN)       c = COLOR_BLACK;
    else if (s < TIER_MID_MIN)   c = COLOR_DARK;
    else if (s < TIER_LIGHT_MIN) c = COLOR_MID;
    else                         c = COLOR_LIGHT;
    return c;
  endfunction

endpackage

// ===== sv/jesc_front.sv =====
module jesc_front #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  jesc_pkg::in_t     in_data,
  input  logic [31:0]       x_scale,
  input  logic [31:0]       y_scale,
  output logic              push,
  output jesc_pkg::job_t    push_data,
  input  logic              push_ready
);

  localparam int PW = jesc_pkg::PSUM_W;
  localparam logic signed [PW-1:0] HALF_W = PW'(SCREEN_WIDTH / 2);
  localparam logic signed [PW-1:0] HALF_H = PW'(SCREEN_HEIGHT / 2);
  localparam logic signed [PW-1:0] LIM_W  = PW'(SCREEN_WIDTH - 1);
  localparam logic signed [PW-1:0] LIM_H  = PW'(SCREEN_HEIGHT - 1);
  localparam logic [63:0] RND = 64'h0000_0FFF_FFFF_FFFF;

  logic                      s1_valid;
  logic signed [31:0]        s1_re;
  logic signed [31:0]        s1_im;
  logic signed [63:0]        prod_x;
  logic signed [63:0]        prod_y;
  logic signed [63:0]        rx;
  logic signed [63:0]        ry;
  logic signed [PW-1:0]      sum_x;
  logic signed [PW-1:0]      sum_y;
  logic signed [PW-1:0]      pos_x;
  logic signed [PW-1:0]      pos_y;
  logic                      clamp_x;
  logic                      clamp_y;

  assign in_ready = !s1_valid || push_ready;
  assign push     = s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (push_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_re  <= in_data.point_real;
      s1_im  <= in_data.point_imag;
      prod_x <= $signed({{32{in_data.point_real[31]}}, in_data.point_real})
                * $signed({32'd0, x_scale});
      prod_y <= $signed({{32{in_data.point_imag[31]}}, in_data.point_imag})
                * $signed({32'd0, y_scale});
    end
  end

  // truncate toward zero on the 2^44 shift
  always_comb begin
    rx    = prod_x + (prod_x[63] ? $signed(RND) : 64'sd0);
    ry    = prod_y + (prod_y[63] ? $signed(RND) : 64'sd0);
    sum_x = HALF_W + PW'($signed(rx[63:44]));
    sum_y = HALF_H - PW'($signed(ry[63:44]));
    clamp_x = 1'b0;
    clamp_y = 1'b0;
    pos_x = sum_x;
    pos_y = sum_y;
    if (sum_x < 0) begin
      pos_x = '0; clamp_x = 1'b1;
    end else if (sum_x > LIM_W) begin
      pos_x = LIM_W; clamp_x = 1'b1;
    end
    if (sum_y < 0) begin
      pos_y = '0; clamp_y = 1'b1;
    end else if (sum_y > LIM_H) begin
      pos_y = LIM_H; clamp_y = 1'b1;
    end
    push_data.z_re      = s1_re;
    push_data.z_im      = s1_im;
    push_data.pixel_x   = pos_x[jesc_pkg::PIX_W-1:0];
    push_data.pixel_y   = pos_y[jesc_pkg::PIX_W-1:0];
    push_data.offscreen = clamp_x || clamp_y;
  end

endmodule

// ===== sv/jesc_queue.sv =====
module jesc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  jesc_pkg::job_t push_data,
  output logic           push_ready,
  input  logic           pop,
  output jesc_pkg::job_t pop_data,
  output logic           pop_valid
);

  jesc_pkg::job_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

// ===== sv/jesc_back.sv =====
module jesc_back #(
  parameter int MAX_ITER = 300
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  jesc_pkg::job_t     job,
  output logic               pop,
  input  logic signed [31:0] c_real,
  input  logic signed [31:0] c_imag,
  output logic               out_valid,
  input  logic               out_ready,
  output jesc_pkg::out_t     out_data
);

  localparam int SW = $clog2(MAX_ITER + 1);
  localparam logic [SW-1:0] LAST = SW'(MAX_ITER);

  jesc_pkg::back_state_t state, state_next;

  logic signed [37:0] re;
  logic signed [37:0] im;
  logic [SW-1:0]      step;
  logic signed [63:0] prr;
  logic signed [63:0] pii;
  logic signed [63:0] pri;
  jesc_pkg::job_t     cur;

  logic [63:0]        sumsq;
  logic signed [63:0] diff;
  logic signed [37:0] nre;
  logic signed [37:0] nim;
  logic               big;
  logic               out_r;
  logic               at_end;
  logic               finish;
  logic               fin_esc;
  logic [SW-1:0]      fin_step;
  logic               load;
  logic               advance;

  // escape tests: |z|^2 > 4 on the squares of the value made by the previous step, +/-2 box on the new value
  always_comb begin
    sumsq = prr + pii;
    diff  = prr - pii;
    nre   = 38'($signed(diff[63:28])) + 38'(c_real);
    nim   = 38'($signed(pri[63:27])) + 38'(c_imag);
    big   = (step != '0) && (sumsq > jesc_pkg::FOUR_Q56);
    at_end = (step == LAST);
    out_r = (nre > jesc_pkg::TWO_Q28) || (nre < -jesc_pkg::TWO_Q28) ||
            (nim > jesc_pkg::TWO_Q28) || (nim < -jesc_pkg::TWO_Q28);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      jesc_pkg::B_IDLE: if (job_valid && !out_valid) state_next = jesc_pkg::B_MUL;
      jesc_pkg::B_MUL:  state_next = jesc_pkg::B_ADD;
      jesc_pkg::B_ADD:  state_next = (big || at_end || out_r) ? jesc_pkg::B_IDLE
                                                              : jesc_pkg::B_MUL;
      default:          state_next = jesc_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    load     = 1'b0;
    advance  = 1'b0;
    finish   = 1'b0;
    fin_esc  = 1'b0;
    fin_step = step;
    unique case (state)
      jesc_pkg::B_IDLE: load = job_valid && !out_valid;
      jesc_pkg::B_MUL:  ;
      jesc_pkg::B_ADD: begin
        if (big) begin
          finish = 1'b1; fin_esc = 1'b1; fin_step = step - SW'(1);
        end else if (at_end) begin
          finish = 1'b1;
        end else if (out_r) begin
          finish = 1'b1; fin_esc = 1'b1;
        end else begin
          advance = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= jesc_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish)                      out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur  <= job;
      re   <= 38'(job.z_re);
      im   <= 38'(job.z_im);
      step <= '0;
    end else if (advance) begin
      re   <= nre;
      im   <= nim;
      step <= step + SW'(1);
    end
    if (state == jesc_pkg::B_MUL) begin
      prr <= $signed(re[31:0]) * $signed(re[31:0]);
      pii <= $signed(im[31:0]) * $signed(im[31:0]);
      pri <= $signed(re[31:0]) * $signed(im[31:0]);
    end
    if (finish) begin
      out_data.pixel_x     <= cur.pixel_x;
      out_data.pixel_y     <= cur.pixel_y;
      out_data.offscreen   <= cur.offscreen;
      out_data.escape_step <= jesc_pkg::STEP_W'(fin_step);
      out_data.escaped     <= fin_esc;
      out_data.pixel_color <= fin_esc ? jesc_pkg::tier_color(16'(fin_step))
                                      : jesc_pkg::COLOR_WHITE;
    end
  end

endmodule

// ===== sv/julia_escape_time_pixel_core.sv =====
// The back runs k multiply/add rounds per point, k being s+1 when the new z leaves the +/-2
// box at step s, s+2 when only |z|^2 > 4 flags it, and MAX_ITER+1 for a bounded orbit.
// The back takes the next point only after its result is transferred; the front and queue
// overlap the orbit and keep taking points meanwhile.
// Reset (rst, synchronous, active high) empties the front, queue and output register and
// loads c = 0 and both scales with 200.0.
module julia_escape_time_pixel_core #(
  parameter int MAX_ITER      = 300,
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  // point channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  jesc_pkg::in_t                      in_data,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output jesc_pkg::out_t                     out_data,
  // register writes
  input  logic                               cfg_we,
  input  logic [jesc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data
);

  // configuration registers; unknown indexes are dropped
  logic signed [31:0] c_real;
  logic signed [31:0] c_imag;
  logic [31:0]        x_scale;
  logic [31:0]        y_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_real  <= '0;
      c_imag  <= '0;
      x_scale <= jesc_pkg::SCALE_RESET;
      y_scale <= jesc_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        jesc_pkg::REG_C_REAL:  c_real  <= cfg_data;
        jesc_pkg::REG_C_IMAG:  c_imag  <= cfg_data;
        jesc_pkg::REG_X_SCALE: x_scale <= cfg_data;
        jesc_pkg::REG_Y_SCALE: y_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: takes a point, works out its clamped pixel
  logic           push;
  logic           push_ready;
  jesc_pkg::job_t push_data;

  jesc_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .x_scale   (x_scale),
    .y_scale   (y_scale),
    .push      (push),
    .push_data (push_data),
    .push_ready(push_ready)
  );

  // two-entry queue so the front keeps taking points during an orbit
  logic           pop;
  logic           job_valid;
  jesc_pkg::job_t job;

  jesc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .push_ready(push_ready),
    .pop       (pop),
    .pop_data  (job),
    .pop_valid (job_valid)
  );

  // back: iterates z = z*z + c, a multiply state and then an add/test state
  // per step, and holds the result until its transfer
  jesc_back #(
    .MAX_ITER(MAX_ITER)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(job_valid),
    .job      (job),
    .pop      (pop),
    .c_real   (c_real),
    .c_imag   (c_imag),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== sv/jesc_checker.sv =====
module jesc_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_ready,
  input jesc_pkg::out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_white: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.escaped |-> out_data.pixel_color == jesc_pkg::COLOR_WHITE)
    else $error("bounded orbit not white");

  a_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.escaped && out_data.escape_step < 9'd11
      |-> out_data.pixel_color == jesc_pkg::COLOR_BLACK)
    else $error("early escape not black");

endmodule

bind julia_escape_time_pixel_core jesc_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

// ===== dv/tb_julia_escape_time_pixel_core.sv =====
module tb_julia_escape_time_pixel_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ITER = 300;
  localparam int SCREEN_WIDTH = 1024;
  localparam int SCREEN_HEIGHT = 1024;
  // any index above the last register, must be ignored
  localparam logic [jesc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 8'd4;
  localparam logic [jesc_pkg::CFG_IDX_W-1:0] REG_TOP_IDX  = 8'hff;
  // watchdog: cycles without any transfer; covers the long hold plus
  // a full 300-step orbit several times over
  localparam int STALL_LIMIT = 40000;
  localparam int LONG_HOLD = 3000;
  localparam int RANDOM_ITEMS = 2000;

  logic            clk = 1'b0;
  logic            rst;
  logic            in_valid;
  logic            in_ready;
  jesc_pkg::in_t   in_data;
  logic            out_valid;
  logic            out_ready;
  jesc_pkg::out_t  out_data;
  logic            cfg_we;
  logic [jesc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  julia_escape_time_pixel_core #(
    .MAX_ITER(MAX_ITER),
    .SCREEN_WIDTH(SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // local copy of the register file
  logic signed [31:0] c_re_q, c_im_q;
  logic [31:0] x_scale_q, y_scale_q;

  jesc_pkg::out_t pixel_queue[$];   // expected results, oldest first
  int   mismatches = 0;
  int   idle_cycles = 0;
  int   burst_left = 0;
  int   hold_req = 0;     // set by a test, counted down by the receiver

  // ---------------------------------------------------------------
  // Escape-time and pixel prediction from the current register copy
  // ---------------------------------------------------------------
  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint trunc44(longint v);
    return (v < 0) ? -((-v) >>> 44) : (v >>> 44);
  endfunction

  function automatic jesc_pkg::out_t predict_pixel(jesc_pkg::in_t p);
    longint re, im, nre, nim, x0, y0, px, py;
    longint two, four;
    int step;
    bit esc, clamped;
    jesc_pkg::out_t r;
    two = longint'(1) << 29;
    four = longint'(1) << 58;
    x0 = longint'($signed(p.point_real));
    y0 = longint'($signed(p.point_imag));
    re = x0;
    im = y0;
    step = MAX_ITER;
    esc = 1'b0;
    for (int i = 0; i < MAX_ITER; i++) begin
      // arithmetic shift of a signed value is floor division
      nre = ((re * re - im * im) >>> 28) + longint'(c_re_q);
      nim = ((re * im) >>> 27) + longint'(c_im_q);
      // magnitude guard first so the squares cannot overflow
      if (abs64(nre) > two || abs64(nim) > two || nre * nre + nim * nim > four) begin
        esc = 1'b1;
        step = i;
        break;
      end
      re = nre;
      im = nim;
    end
    if (!esc)            r.pixel_color = jesc_pkg::COLOR_WHITE;
    else if (step <= 10) r.pixel_color = jesc_pkg::COLOR_BLACK;
    else if (step <= 20) r.pixel_color = jesc_pkg::COLOR_DARK;
    else if (step <= 59) r.pixel_color = jesc_pkg::COLOR_MID;
    else                 r.pixel_color = jesc_pkg::COLOR_LIGHT;
    clamped = 1'b0;
    px = SCREEN_WIDTH / 2 + trunc44(x0 * longint'(x_scale_q));
    py = SCREEN_HEIGHT / 2 - trunc44(y0 * longint'(y_scale_q));
    if (px < 0) begin
      px = 0; clamped = 1'b1;
    end else if (px > SCREEN_WIDTH - 1) begin
      px = SCREEN_WIDTH - 1; clamped = 1'b1;
    end
    if (py < 0) begin
      py = 0; clamped = 1'b1;
    end else if (py > SCREEN_HEIGHT - 1) begin
      py = SCREEN_HEIGHT - 1; clamped = 1'b1;
    end
    r.pixel_x = px[jesc_pkg::PIX_W-1:0];
    r.pixel_y = py[jesc_pkg::PIX_W-1:0];
    r.offscreen = clamped;
    r.escape_step = step[jesc_pkg::STEP_W-1:0];
    r.escaped = esc;
    return r;
  endfunction

  // ---------------------------------------------------------------
  // Result checker and receiver stall pattern. Handshake signals are
  // read at the edge, before this edge's updates land.
  // ---------------------------------------------------------------
  int stall_pct = 0;
  int phase_cnt = 0;
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pixel_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transfer: %p", out_data);
        end else begin
          jesc_pkg::out_t e;
          e = pixel_queue.pop_front();
          if (e !== out_data) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p actual %p", e, out_data);
          end
        end
      end
      // a long hold request takes priority over the random pattern
      if (hold_req > 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (phase_cnt == 0) begin
        phase_cnt = $urandom_range(64, 512);
        case ($urandom_range(3))
          0, 1: stall_pct = 0;
          2: stall_pct = 30;
          default: stall_pct = 80;
        endcase
      end
      phase_cnt--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog: any transfer on either channel resets the count
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------
  // Offer one point and hold it until its transfer; valid stays high on
  // return so back-to-back points never drop it.
  task automatic send_point(logic [31:0] re, logic [31:0] im);
    jesc_pkg::in_t p;
    if (burst_left == 0) begin
      int gap;
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    p.point_real = re;
    p.point_imag = im;
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (!in_ready);
    pixel_queue.push_back(predict_pixel(p));
  endtask

  // stop offering and wait until every expected result is back
  task automatic drain;
    in_valid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // one write, then the enable drops before returning so back-to-back writes never assign
  // the enable twice at the same edge
  task automatic write_reg(logic [jesc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      jesc_pkg::REG_C_REAL:  c_re_q = val;
      jesc_pkg::REG_C_IMAG:  c_im_q = val;
      jesc_pkg::REG_X_SCALE: x_scale_q = val;
      jesc_pkg::REG_Y_SCALE: y_scale_q = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] cr, logic [31:0] ci, logic [31:0] xs, logic [31:0] ys);
    drain();
    write_reg(jesc_pkg::REG_C_REAL, cr);
    write_reg(jesc_pkg::REG_C_IMAG, ci);
    write_reg(jesc_pkg::REG_X_SCALE, xs);
    write_reg(jesc_pkg::REG_Y_SCALE, ys);
  endtask

  // point mostly inside the +/-2 box, sometimes anywhere in the field
  task automatic send_random_point;
    logic [31:0] re, im;
    if ($urandom_range(99) < 45) begin
      re = $urandom;
      im = $urandom;
    end else begin
      re = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
      im = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
    end
    send_point(re, im);
  endtask

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------
  task automatic test_directed;
    // reset values: c = 0, scales 200.0
    send_point(32'h0, 32'h0);                  // bounded, white
    send_point(32'h7fff_ffff, 32'h7fff_ffff);  // largest point, escapes at once
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7fff_ffff);
    send_point(32'h7fff_ffff, 32'h8000_0000);
    send_point(32'h1000_0000, 32'h0);          // 1.0 stays on unit circle
    send_point(32'h1000_0001, 32'h0);          // just outside, slow escape
    send_point(32'h0, 32'h1000_0000);
    send_point(32'h2000_0000, 32'h0);          // exactly 2.0
    send_point(32'hfc00_0000, 32'h0500_0000);  // pixel left of and above the centre
    send_point(32'h0290_0000, 32'hfd70_0000);  // pixel right of and below the centre
    // zero scale puts every point on the centre
    set_regs(32'h0, 32'h0, 32'h0, 32'h0);
    send_point(32'h7fff_ffff, 32'h8000_0000);
    send_point(32'h0123_4567, 32'hfedc_ba98);
    // maximum scale clamps almost everything
    set_regs(32'h0, 32'h0, 32'hffff_ffff, 32'hffff_ffff);
    send_point(32'h8000_0000, 32'h7fff_ffff);
    send_point(32'h0000_0001, 32'hffff_ffff);
    send_point(32'h0, 32'h0);
    // extreme constants: escape on the first step
    set_regs(32'h7fff_ffff, 32'h8000_0000, jesc_pkg::SCALE_RESET, jesc_pkg::SCALE_RESET);
    send_point(32'h0, 32'h0);
    set_regs(32'h8000_0000, 32'h7fff_ffff, jesc_pkg::SCALE_RESET, jesc_pkg::SCALE_RESET);
    send_point(32'h0, 32'h0);
    // c = -2: orbit of zero sits on the boundary
    set_regs(32'he000_0000, 32'h0, jesc_pkg::SCALE_RESET, jesc_pkg::SCALE_RESET);
    send_point(32'h0, 32'h0);
    send_point(32'h0000_1000, 32'h0);
    // writes beyond the register file change nothing
    drain();
    write_reg(REG_UNMAPPED, 32'hdead_beef);
    write_reg(REG_TOP_IDX, 32'h1234_5678);
    send_point(32'h0800_0000, 32'h0800_0000);
  endtask

  // random points under several settings, half of them with near-boundary constants
  task automatic test_random_settings(int n_items);
    int per;
    per = n_items / 8;
    for (int k = 0; k < 8; k++) begin
      logic [31:0] cr, ci, xs, ys;
      case (k % 4)
        0: begin
          cr = 32'hf333_3333;  ci = 32'h027e_f9db;  // about -0.8 + 0.156j
        end
        1: begin
          cr = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
          ci = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
        end
        2: begin
          cr = $urandom; ci = $urandom;
        end
        default: begin
          cr = 32'hfbfb_e76c;  ci = 32'h0a4d_0bbb;  // a dendrite-like constant
        end
      endcase
      xs = (k == 2) ? $urandom : $urandom_range(0, 32'h0100_0000);
      ys = (k == 5) ? $urandom : $urandom_range(0, 32'h0100_0000);
      set_regs(cr, ci, xs, ys);
      repeat (per) send_random_point();
    end
  endtask

  // receiver holds off while points keep coming, so the input stalls
  task automatic test_backpressure;
    set_regs(32'hf333_3333, 32'h027e_f9db, jesc_pkg::SCALE_RESET, jesc_pkg::SCALE_RESET);
    hold_req = LONG_HOLD;
    repeat (40) send_random_point();
  endtask

  task automatic test_drain_pause;
    repeat (10) send_random_point();
    drain();
    repeat (10) send_random_point();
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    c_re_q = '0;
    c_im_q = '0;
    x_scale_q = jesc_pkg::SCALE_RESET;
    y_scale_q = jesc_pkg::SCALE_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_settings(RANDOM_ITEMS);
    test_backpressure();
    test_drain_pause();

    drain();
    repeat (700) @(posedge clk);
    if (mismatches == 0 && pixel_queue.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
